// ===== design/srld_pkg.sv =====
// ----------------------------------------------------------------------------
// srld_pkg
// Shared types, character codes and lamp word tables for the status report
// light decoder.
// ----------------------------------------------------------------------------
package srld_pkg;

   // Character codes that steer the line parser.
   localparam logic [7:0] CHAR_OPEN  = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_BAR   = 8'h7C;  // '|'
   localparam logic [7:0] CHAR_CLOSE = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Field length saturates here; no exact word is longer than five.
   localparam logic [2:0] LEN_SAT = 3'd6;

   // Lamp indexes within the match flags.
   localparam int LAMP_COUNT = 4;
   localparam int LAMP_IDLE  = 0;
   localparam int LAMP_RUN   = 1;
   localparam int LAMP_HOLD  = 2;
   localparam int LAMP_ALARM = 3;
   localparam int WORD_MAX   = 5;

   // Lamp words, first character in the low byte.
   localparam logic [8*WORD_MAX-1:0] LAMP_WORD [LAMP_COUNT] = '{
      40'h00_65_6C_64_49,   // Idle
      40'h00_00_6E_75_52,   // Run
      40'h00_64_6C_6F_48,   // Hold
      40'h6D_72_61_6C_41    // Alarm
   };
   localparam logic [2:0] LAMP_LEN [LAMP_COUNT] = '{3'd4, 3'd3, 3'd4, 3'd5};
   localparam logic [LAMP_COUNT-1:0] LAMP_EXACT = 4'b1011;

   // Line parser phase.
   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_FIELD  = 2'd1,
      PH_CLOSED = 2'd2,
      PH_OTHER  = 2'd3
   } phase_type;

   // Lamp bits of one result.
   typedef struct packed {
      logic alarm_on;
      logic hold_on;
      logic run_on;
      logic idle_on;
   } lamps_type;

   // Result handed from the decoder to the output register.
   typedef struct packed {
      logic      load;
      lamps_type lamps;
   } result_type;

   // Returns whether a word stays matched after character c at position pos.
   function automatic logic char_keep(input int unsigned k, input logic [2:0] pos,
                                      input logic [7:0] c);
      logic keep;
      keep = !LAMP_EXACT[k];
      if (pos < LAMP_LEN[k]) begin
         keep = 1'b0;
         for (int i = 0; i < WORD_MAX; i++) begin
            if (pos == i[2:0] && c == LAMP_WORD[k][8*i +: 8]) begin
               keep = 1'b1;
            end
         end
      end
      return keep;
   endfunction

endpackage

// ===== design/srld_channels.sv =====
// ----------------------------------------------------------------------------
// srld_channels
// Valid/ready channel interfaces for incoming text bytes and lamp results.
// ----------------------------------------------------------------------------

// Request channel: one received character per request.
interface srld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel: four lamp bits per finished status line.
interface srld_rsp_if;
   logic valid;
   logic ready;
   logic idle_on;
   logic run_on;
   logic hold_on;
   logic alarm_on;

   modport source (output valid, output idle_on, output run_on, output hold_on,
                   output alarm_on, input ready);
   modport sink (input valid, input idle_on, input run_on, input hold_on,
                 input alarm_on, output ready);
endinterface

// ===== design/srld_in_stage.sv =====
// ----------------------------------------------------------------------------
// srld_in_stage
// Input register that holds one accepted character until the decoder
// consumes it.
// ----------------------------------------------------------------------------
module srld_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   output logic       req_ready,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   // A new request is taken whenever the held one is empty or leaves now.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads on acceptance only.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

// ===== design/srld_decode.sv =====
// ----------------------------------------------------------------------------
// srld_decode
// Per-character line parser: tracks the line phase and the prefix match of
// the first field, and forms the lamp bits when a status line ends.
// ----------------------------------------------------------------------------
module srld_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            byte_data,
   output srld_pkg::result_type  result
);

   srld_pkg::phase_type                  phase_ff, phase_in;
   logic [2:0]                           length_ff, length_in;
   logic [srld_pkg::LAMP_COUNT-1:0]      flags_ff, flags_in;
   logic [srld_pkg::LAMP_COUNT-1:0]      prior_ff, prior_in;
   logic                                 close_ff, close_in;

   logic                                 is_cr, is_lf, take_char;
   logic                                 use_prior;
   logic [srld_pkg::LAMP_COUNT-1:0]      char_flags, sel_flags;
   logic [2:0]                           sel_len;

   assign is_cr = (byte_data == srld_pkg::CHAR_CR);
   assign is_lf = (byte_data == srld_pkg::CHAR_LF);

   // A field character is any ordinary byte inside the first field but the bar.
   assign take_char = !is_cr && !is_lf && (phase_ff == srld_pkg::PH_FIELD)
                      && (byte_data != srld_pkg::CHAR_BAR);

   // Match flags after this character, one compare per lamp word.
   always_comb begin
      for (int k = 0; k < srld_pkg::LAMP_COUNT; k++) begin
         char_flags[k] = flags_ff[k] && srld_pkg::char_keep(k, length_ff, byte_data);
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (is_lf) begin
         phase_in = srld_pkg::PH_START;
      end else if (!is_cr) begin
         unique case (phase_ff)
            srld_pkg::PH_START: begin
               phase_in = (byte_data == srld_pkg::CHAR_OPEN) ? srld_pkg::PH_FIELD
                                                              : srld_pkg::PH_OTHER;
            end
            srld_pkg::PH_FIELD: begin
               if (byte_data == srld_pkg::CHAR_BAR) begin
                  phase_in = srld_pkg::PH_CLOSED;
               end
            end
            srld_pkg::PH_CLOSED,
            srld_pkg::PH_OTHER: begin
               phase_in = phase_ff;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Field match state; a line feed starts everything over.
   always_comb begin
      length_in = length_ff;
      flags_in  = flags_ff;
      prior_in  = prior_ff;
      close_in  = close_ff;
      if (is_lf) begin
         length_in = '0;
         flags_in  = '1;
         prior_in  = '1;
         close_in  = 1'b0;
      end else if (take_char) begin
         prior_in  = flags_ff;
         flags_in  = char_flags;
         length_in = (length_ff < srld_pkg::LEN_SAT) ? length_ff + 3'd1 : length_ff;
         close_in  = (byte_data == srld_pkg::CHAR_CLOSE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= srld_pkg::PH_START;
         length_ff <= '0;
         flags_ff  <= '1;
         prior_ff  <= '1;
         close_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         flags_ff  <= flags_in;
         prior_ff  <= prior_in;
         close_ff  <= close_in;
      end
   end

   // Without a bar, a trailing close mark is dropped from the field.
   assign use_prior = (phase_ff == srld_pkg::PH_FIELD) && close_ff && (length_ff != 3'd0);
   assign sel_flags = use_prior ? prior_ff : flags_ff;
   assign sel_len   = use_prior ? length_ff - 3'd1 : length_ff;

   // Lamp bits and load strobe for the output register.
   always_comb begin
      result.load = advance && is_lf
                    && (phase_ff == srld_pkg::PH_FIELD || phase_ff == srld_pkg::PH_CLOSED);
      result.lamps.idle_on  = sel_flags[srld_pkg::LAMP_IDLE]
                              && (sel_len == srld_pkg::LAMP_LEN[srld_pkg::LAMP_IDLE]);
      result.lamps.run_on   = sel_flags[srld_pkg::LAMP_RUN]
                              && (sel_len == srld_pkg::LAMP_LEN[srld_pkg::LAMP_RUN]);
      result.lamps.hold_on  = sel_flags[srld_pkg::LAMP_HOLD]
                              && (sel_len >= srld_pkg::LAMP_LEN[srld_pkg::LAMP_HOLD]);
      result.lamps.alarm_on = sel_flags[srld_pkg::LAMP_ALARM]
                              && (sel_len == srld_pkg::LAMP_LEN[srld_pkg::LAMP_ALARM]);
   end

   // The field length never passes its saturation point.
   a_length_sat: assert property (@(posedge clock) disable iff (reset)
      length_ff <= srld_pkg::LEN_SAT)
      else $error("field length above saturation");

   // A processed line feed leaves a fresh line behind.
   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      advance && is_lf |=> phase_ff == srld_pkg::PH_START && length_ff == 3'd0
                           && flags_ff == '1)
      else $error("line feed did not clear the line state");

   // A result is only formed from a line feed that is being processed.
   a_load_on_lf: assert property (@(posedge clock) disable iff (reset)
      result.load |-> advance && is_lf)
      else $error("result load without line feed");

   // Before the first field opens, nothing is counted.
   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == srld_pkg::PH_START |-> length_ff == 3'd0 && !close_ff)
      else $error("line start with field state");

endmodule

// ===== design/srld_rsp_stage.sv =====
// ----------------------------------------------------------------------------
// srld_rsp_stage
// Output register that holds one lamp result until the consumer takes it.
// ----------------------------------------------------------------------------
module srld_rsp_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  srld_pkg::result_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output srld_pkg::lamps_type  rsp_lamps
);

   logic                valid_ff, valid_in;
   srld_pkg::lamps_type lamps_ff;

   // The register can take a new result when empty or emptied this cycle.
   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = result.load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         lamps_ff <= result.lamps;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_lamps = lamps_ff;

endmodule

// ===== design/status_report_light_decoder_top.sv =====
// The request carrying the line feed is accepted into the input register, and
// the output register loads the lamp result when the parser advances on it.
// Throughput: one character per cycle while no result stalls; each byte passes
// once through the input register, the line parser and the output register.
// A stalled result holds the parser, and new requests back up behind it.
// Reset (synchronous, active high) empties both registers and starts a fresh line.
// ----------------------------------------------------------------------------
// status_report_light_decoder_top
// Decodes status text lines into four lamp bits: idle, run, hold and alarm.
// ----------------------------------------------------------------------------
module status_report_light_decoder_top (
   input  logic              clock,
   input  logic              reset,
   srld_req_if.sink          req_ch,
   srld_rsp_if.source        rsp_ch
);

   logic                 advance;
   logic                 out_free;
   logic                 byte_valid;
   logic [7:0]           byte_data;
   srld_pkg::result_type result;
   srld_pkg::lamps_type  rsp_lamps;
   logic                 rsp_valid;

   // The parser moves whenever a character is held and the output can take it.
   assign advance = byte_valid && out_free;

   srld_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_rx_byte (req_ch.rx_byte),
      .req_ready   (req_ch.ready),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   srld_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .byte_data (byte_data),
      .result    (result)
   );

   srld_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_lamps (rsp_lamps)
   );

   // Result channel payload.
   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.idle_on  = rsp_lamps.idle_on;
   assign rsp_ch.run_on   = rsp_lamps.run_on;
   assign rsp_ch.hold_on  = rsp_lamps.hold_on;
   assign rsp_ch.alarm_on = rsp_lamps.alarm_on;

endmodule
